// File: rtl/fifo_queue_with_delete_by_value_unit_macros.svh
// Assertion macros for the fifo queue with delete-by-value unit.
// Used by rtl/fifo_queue_with_delete_by_value_unit.sv; expects clk and rst_n in scope.
`ifndef FIFO_QUEUE_WITH_DELETE_BY_VALUE_UNIT_MACROS_SVH
`define FIFO_QUEUE_WITH_DELETE_BY_VALUE_UNIT_MACROS_SVH

// property checked on every clock outside reset
`define FQD_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication checked on every clock outside reset
`define FQD_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define FQD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fqd_pkg.sv
// Package for the fifo queue with delete-by-value unit: codes, payload and control types.
// No dependencies.
`default_nettype none

package fqd_pkg;

    localparam int REQ_DATA_W  = 32;
    localparam int RSP_COUNT_W = 5;

    typedef enum logic [1:0] {
        MODE_ENQ = 2'd0,
        MODE_DEQ = 2'd1,
        MODE_DEL = 2'd2,
        MODE_NOP = 2'd3
    } fqd_mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } fqd_status_t;

    typedef struct packed {
        fqd_mode_t               mode;
        logic [REQ_DATA_W-1:0]   data_in;
    } fqd_req_t;

    typedef struct packed {
        fqd_status_t             status;
        logic [REQ_DATA_W-1:0]   data_out;
        logic [RSP_COUNT_W-1:0]  count;
    } fqd_rsp_t;

    // qualified per-transaction operation, already checked for success
    typedef struct packed {
        logic enq;
        logic deq;
        logic del;
    } fqd_ctl_t;

endpackage

`default_nettype wire

// File: rtl/fqd_cell.sv
// One queue entry cell: holds a word, matches it, shifts from its upper neighbor.
// Depends on fqd_pkg.
`default_nettype none

module fqd_cell
    import fqd_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int WORD_W = 32,
    parameter int CNT_W  = 5
)
(
    input  wire logic              clk,
    input  wire fqd_ctl_t          ctl,
    input  wire logic [CNT_W-1:0]  count,
    input  wire logic [WORD_W-1:0] word,
    input  wire logic [WORD_W-1:0] next_data,
    input  wire logic              hit_in,
    output logic      [WORD_W-1:0] data,
    output logic                   hit_out
);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              occupied;
    logic              match;
    logic              load_here;
    logic              shift;

    assign occupied  = count > CNT_W'(IDX);
    assign match     = occupied && (data_reg == word);
    assign hit_out   = hit_in || match;
    assign load_here = ctl.enq && (count == CNT_W'(IDX));
    // at and above the deleted entry everything moves down one place
    assign shift     = ctl.deq || (ctl.del && hit_out);

    always_comb
    begin
        data_next = data_reg;
        if (load_here)
        begin
            data_next = word;
        end
        else if (shift)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// File: rtl/fifo_queue_with_delete_by_value_unit.sv
// Top level of the fifo queue with delete-by-value unit: control, count and result register.
// Depends on fqd_pkg, fqd_cell and fifo_queue_with_delete_by_value_unit_macros.svh.
//
// Usage:
//   req channel (req_valid, req_stall, req) carries one operation per transaction:
//   enqueue, dequeue, delete of the oldest matching word, or no-op.
//   rsp channel (rsp_valid, rsp_stall, rsp) returns one result per transaction:
//   status, the dequeued word (zero otherwise) and the entry count afterwards.
//   The result is registered: rsp and rsp_valid are loaded as the transaction is accepted.
//   Throughput is one transaction per cycle while no result is held by rsp_stall; the
//   entries sit in a row of cells and the match, first-hit ripple and shift of the
//   whole row finish in the cycle the transaction is accepted.
//   Reset empties the queue (count zero) and clears rsp_valid; entry contents are
//   left as they are and never read before being written.
//   While rsp_stall holds a waiting result, req_stall is raised and the result and
//   the queue stay unchanged; a new transaction is taken in the cycle the result
//   leaves.
`default_nettype none
`include "fifo_queue_with_delete_by_value_unit_macros.svh"

module fifo_queue_with_delete_by_value_unit
    import fqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int WORD_WIDTH  = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire fqd_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output fqd_rsp_t      rsp
);

    localparam int SW    = (WORD_WIDTH < REQ_DATA_W) ? WORD_WIDTH : REQ_DATA_W;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    fqd_rsp_t         rsp_reg;
    fqd_rsp_t         rsp_next;

    logic             req_accept;
    logic [SW-1:0]    word;
    logic             word_nz;
    logic             full;
    logic             empty;
    fqd_ctl_t         ctl;
    fqd_status_t      status;
    logic [SW-1:0]    removed;

    logic [SW-1:0]    cell_data [QUEUE_DEPTH];
    logic             hit [QUEUE_DEPTH+1];

    assign req_stall  = rsp_valid_reg && rsp_stall;
    assign req_accept = req_valid && !req_stall;

    assign word    = req.data_in[SW-1:0];
    assign word_nz = |word;
    assign full    = count_reg == DEPTH_CNT;
    assign empty   = count_reg == '0;

    assign hit[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [SW-1:0] upper;
        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign upper = cell_data[i];
        end
        else
        begin : g_mid
            assign upper = cell_data[i+1];
        end

        fqd_cell #(
            .IDX    (i),
            .WORD_W (SW),
            .CNT_W  (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .count     (count_reg),
            .word      (word),
            .next_data (upper),
            .hit_in    (hit[i]),
            .data      (cell_data[i]),
            .hit_out   (hit[i+1])
        );
    end

    always_comb
    begin
        ctl        = '0;
        status     = ST_OK;
        removed    = '0;
        count_next = count_reg;
        if (req_accept)
        begin
            unique case (req.mode)
                MODE_ENQ:
                begin
                    if (!word_nz)
                    begin
                        status = ST_NULL;
                    end
                    else if (full)
                    begin
                        status = ST_FULL;
                    end
                    else
                    begin
                        ctl.enq    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_DEQ:
                begin
                    if (empty)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.deq    = 1'b1;
                        removed    = cell_data[0];
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_DEL:
                begin
                    if (!word_nz)
                    begin
                        status = ST_NULL;
                    end
                    else if (empty)
                    begin
                        status = ST_EMPTY;
                    end
                    else if (hit[QUEUE_DEPTH])
                    begin
                        ctl.del    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status = ST_NOTFOUND;
                    end
                end
                MODE_NOP:
                begin
                    status = ST_OK;
                end
                default:
                begin
                    status = ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_next.status   = status;
        rsp_next.data_out = REQ_DATA_W'(removed);
        rsp_next.count    = RSP_COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `FQD_ASSERT(a_count_bound, count_reg <= DEPTH_CNT, "entry count above capacity")
    `FQD_ASSERT_NEXT(a_count_hold, !req_accept, $stable(count_reg),
        "count moved without transaction")
    `FQD_ASSERT_IMPL(a_rsp_count, rsp_valid_reg, rsp_reg.count == RSP_COUNT_W'(count_reg),
        "result count differs from queue count")
    `FQD_ASSERT_IMPL(a_data_ok, rsp_valid_reg && (rsp_reg.data_out != '0),
        rsp_reg.status == ST_OK, "word returned with failing status")

endmodule

`default_nettype wire

// File: verif/fifo_queue_with_delete_by_value_unit_tb.sv
// Testbench for fifo_queue_with_delete_by_value_unit: a directed table, then random traffic,
// every response checked against a fixed table response or a queue model kept in this file.
// Depends on fqd_pkg and the unit's RTL.
module fifo_queue_with_delete_by_value_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fqd_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int WORD_WIDTH   = 32;
    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_ITEMS  = 100;
    localparam int DIR_ROWS     = 18;

    typedef struct packed {
        fqd_mode_t               mode;
        logic [WORD_WIDTH-1:0]   data;
        logic [4:0]              reps;
        logic                    fixed;
        fqd_rsp_t                rsp;
    } dir_row_t;

    // fixed rows carry their response; the rest are predicted
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{MODE_DEQ, 32'h0000_0000, 5'd1,  1'b1, '{ST_EMPTY, 32'h0, 5'd0}},
        '{MODE_DEL, 32'h0000_0005, 5'd1,  1'b1, '{ST_EMPTY, 32'h0, 5'd0}},
        '{MODE_DEL, 32'h0000_0000, 5'd1,  1'b1, '{ST_NULL,  32'h0, 5'd0}},
        '{MODE_ENQ, 32'h0000_0000, 5'd1,  1'b1, '{ST_NULL,  32'h0, 5'd0}},
        '{MODE_NOP, 32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_OK,    32'h0, 5'd0}},
        '{MODE_ENQ, 32'hFFFF_FFFF, 5'd1,  1'b1, '{ST_OK,    32'h0, 5'd1}},
        '{MODE_ENQ, 32'h0000_0001, 5'd1,  1'b0, '{ST_OK,    32'h0, 5'd0}},
        '{MODE_ENQ, 32'h8000_0000, 5'd1,  1'b0, '{ST_OK,    32'h0, 5'd0}},
        '{MODE_DEL, 32'h1234_5678, 5'd1,  1'b0, '{ST_OK,    32'h0, 5'd0}},
        '{MODE_ENQ, 32'h0000_0001, 5'd1,  1'b0, '{ST_OK,    32'h0, 5'd0}},
        '{MODE_ENQ, 32'h0000_0002, 5'd12, 1'b0, '{ST_OK,    32'h0, 5'd0}},
        '{MODE_ENQ, 32'h0000_0007, 5'd1,  1'b0, '{ST_OK,    32'h0, 5'd0}},
        '{MODE_ENQ, 32'h0000_0000, 5'd1,  1'b0, '{ST_OK,    32'h0, 5'd0}},
        '{MODE_NOP, 32'h0000_0000, 5'd1,  1'b0, '{ST_OK,    32'h0, 5'd0}},
        '{MODE_DEL, 32'h0000_0001, 5'd1,  1'b0, '{ST_OK,    32'h0, 5'd0}},
        '{MODE_DEQ, 32'hAAAA_AAAA, 5'd1,  1'b0, '{ST_OK,    32'h0, 5'd0}},
        '{MODE_DEL, 32'h0000_000D, 5'd1,  1'b0, '{ST_OK,    32'h0, 5'd0}},
        '{MODE_DEL, 32'h0000_0001, 5'd1,  1'b0, '{ST_OK,    32'h0, 5'd0}}
    };

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    fqd_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    fqd_rsp_t rsp;

    logic [WORD_WIDTH-1:0] queue_words [$];
    fqd_rsp_t              pending_rsps [$];
    fqd_rsp_t              oldest_rsp;
    int                    mismatches;
    int                    idle_cycles;
    bit                    quiet;

    fifo_queue_with_delete_by_value_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic fqd_rsp_t apply_op(input fqd_req_t op);
        fqd_rsp_t res;
        int       hit;
        res = '0;
        res.status = ST_OK;
        hit = -1;
        case (op.mode)
            MODE_ENQ:
            begin
                if (op.data_in == '0)
                    res.status = ST_NULL;
                else if (queue_words.size() >= QUEUE_DEPTH)
                    res.status = ST_FULL;
                else
                    queue_words.push_back(op.data_in);
            end
            MODE_DEQ:
            begin
                if (queue_words.size() == 0)
                    res.status = ST_EMPTY;
                else
                    res.data_out = queue_words.pop_front();
            end
            MODE_DEL:
            begin
                if (op.data_in == '0)
                    res.status = ST_NULL;
                else if (queue_words.size() == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    foreach (queue_words[i])
                        if (hit < 0 && queue_words[i] == op.data_in)
                            hit = i;
                    if (hit < 0)
                        res.status = ST_NOTFOUND;
                    else
                        queue_words.delete(hit);
                end
            end
            default: ;
        endcase
        res.count = RSP_COUNT_W'(queue_words.size());
        return res;
    endfunction

    function automatic logic [WORD_WIDTH-1:0] random_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return '1;
        if (roll < 40)
            return WORD_WIDTH'($urandom_range(1, 8));
        return $urandom;
    endfunction

    // deletes mostly target a word that is held
    function automatic fqd_req_t pick_op(input int enq_pct);
        fqd_req_t op;
        int       roll;
        roll = $urandom_range(99);
        op.data_in = random_word();
        if (roll < enq_pct)
            op.mode = MODE_ENQ;
        else if (roll < enq_pct + (100 - enq_pct) * 45 / 100)
            op.mode = MODE_DEQ;
        else if (roll < enq_pct + (100 - enq_pct) * 90 / 100)
            op.mode = MODE_DEL;
        else
            op.mode = MODE_NOP;
        if (op.mode == MODE_DEL && queue_words.size() != 0 && $urandom_range(99) < 75)
            op.data_in = queue_words[$urandom_range(queue_words.size() - 1)];
        return op;
    endfunction

    function automatic int gap_len();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(99);
        if (roll < 75)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue(input fqd_req_t op, input bit fixed, input fqd_rsp_t fixed_rsp);
        fqd_rsp_t predicted;
        req       <= op;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = apply_op(op);
        pending_rsps.push_back(fixed ? fixed_rsp : predicted);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        int n;
        n = gap_len();
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsps.size() == 0)
                report_mismatch("response with no transaction outstanding");
            else
            begin
                oldest_rsp = pending_rsps.pop_front();
                if (rsp.status !== oldest_rsp.status)
                    report_mismatch($sformatf("status got %0d exp %0d",
                                              rsp.status, oldest_rsp.status));
                if (rsp.data_out !== oldest_rsp.data_out)
                    report_mismatch($sformatf("data_out got %h exp %h",
                                              rsp.data_out, oldest_rsp.data_out));
                if (rsp.count !== oldest_rsp.count)
                    report_mismatch($sformatf("count got %0d exp %0d",
                                              rsp.count, oldest_rsp.count));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[fifo_queue_with_delete_by_value_unit] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int stall_left;
        int roll;
        stall_left = 0;
        rsp_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
            begin
                stall_left = 0;
                rsp_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 80)
                    rsp_stall <= 1'b0;
                else
                begin
                    stall_left = (roll < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                    rsp_stall <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        fqd_req_t op;
        fqd_rsp_t no_rsp;
        int       phase;
        int       enq_pct;
        mismatches  = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        no_rsp      = '0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
            for (int k = 0; k < DIRECTED_ROWS[i].reps; k++)
            begin
                op.mode    = DIRECTED_ROWS[i].mode;
                op.data_in = WORD_WIDTH'(DIRECTED_ROWS[i].data + k);
                issue(op, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].rsp);
                sender_gap();
            end
        drain();

        enq_pct = 70;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_ITEMS == 0)
            begin
                phase   = n / PHASE_ITEMS;
                quiet   = (phase % 4 == 2);
                enq_pct = (phase % 3 == 0) ? 70 : (phase % 3 == 1) ? 25 : 50;
                if (phase == 7)
                    drain();
            end
            issue(pick_op(enq_pct), 1'b0, no_rsp);
            sender_gap();
        end
        drain();
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("[fifo_queue_with_delete_by_value_unit] OK");
        else
            $display("[fifo_queue_with_delete_by_value_unit] ERROR");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/fqd_pkg.sv
rtl/fqd_cell.sv
rtl/fifo_queue_with_delete_by_value_unit.sv
verif/fifo_queue_with_delete_by_value_unit_tb.sv
